/* sv/bitset_store_with_iterator_top_defines.svh */
// assertion macros for the checker file of the bitset store
// no dependencies; expects clk and rst in the scope of each use
`ifndef BITSET_STORE_WITH_ITERATOR_TOP_DEFINES_SVH
`define BITSET_STORE_WITH_ITERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bsi_pkg.sv */
// shared types and constants of the bitset store with iterator
// op codes and the command and status bundles between controller and datapath
package bsi_pkg;

  localparam int BUCKET_BITS = 32;

  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_ADD       = 4'd1;
  localparam logic [3:0] OP_REMOVE    = 4'd2;
  localparam logic [3:0] OP_CONTAINS  = 4'd3;
  localparam logic [3:0] OP_RANGE     = 4'd4;
  localparam logic [3:0] OP_UNION     = 4'd5;
  localparam logic [3:0] OP_INTERSECT = 4'd6;
  localparam logic [3:0] OP_ANY       = 4'd7;
  localparam logic [3:0] OP_FIRST     = 4'd8;
  localparam logic [3:0] OP_NEXT      = 4'd9;
  localparam logic [3:0] OP_ADD_ITER  = 4'd10;
  localparam logic [3:0] OP_REM_ITER  = 4'd11;

  typedef struct packed {
    logic load;       // latch the input beat
    logic rd;         // read a bucket
    logic scan_rd;    // read address is the scan hit
    logic adv;        // step the range cursor
    logic wr;         // write back the modified bucket
    logic clr;        // empty the whole store
    logic step;       // drop the lowest bit of the iterator snapshot
    logic iter_end;   // iterator runs off the end
    logic iter_load;  // iterator takes the bucket just read
    logic fin;        // capture the result
  } bsi_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       bad;
    logic       len_zero;
    logic       more;
    logic       hit;
    logic       last;
  } bsi_sts_t;

endpackage

/* sv/bsi_datapath.sv */
// datapath of the bitset store: bucket memory, nonzero flags, iterator state
// depends on bsi_pkg for op codes and the command and status bundles
module bsi_datapath
  import bsi_pkg::*;
#(
  parameter int BUCKETS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  bsi_cmd_t    cmd,
  output bsi_sts_t    sts,
  input  logic [3:0]  op,
  input  logic [7:0]  element,
  input  logic [8:0]  range_length,
  input  logic [2:0]  word_index,
  input  logic [31:0] word_bits,
  output logic        found,
  output logic [7:0]  position,
  output logic        at_end,
  output logic        error
);

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = AW + 1;
  localparam int TOTAL = BUCKETS * BUCKET_BITS;

  function automatic logic [4:0] lowest_set(input logic [31:0] w);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  logic [3:0]  op_q;
  logic [7:0]  elem_q;
  logic [8:0]  len_q;
  logic [2:0]  widx_q;
  logic [31:0] wbits_q;
  logic [AW-1:0] cur;

  logic [31:0] mem [BUCKETS];
  logic [BUCKETS-1:0] valid_bits;
  logic [BUCKETS-1:0] nz;
  logic [31:0] rd_q;
  logic        rd_valid;

  logic [AW-1:0] iter_bucket;
  logic [31:0]   iter_mask;
  logic [4:0]    iter_bit;
  logic          iter_done;
  logic          found_q;
  logic          error_q;

  logic [31:0]   word;
  logic          elem_ok;
  logic          word_ok;
  logic [9:0]    range_sum;
  logic [9:0]    range_last;
  logic          range_bad;
  logic          bad;
  logic [AW-1:0] range_first_b;
  logic [AW-1:0] range_last_b;
  logic          last;
  logic [4:0]    lo;
  logic [4:0]    hi;
  logic [31:0]   rmask;
  logic [31:0]   mask_after;
  logic [SW-1:0] scan_start;
  logic          hit;
  logic [AW-1:0] hit_idx;
  logic [AW-1:0] raddr;
  logic [4:0]    bit_sel;
  logic [31:0]   bit_oh;
  logic [31:0]   wdata;
  logic          wr_en;
  logic          found_next;

  // a bucket never written since the last clear reads as empty
  assign word = rd_valid ? rd_q : 32'd0;

  assign elem_ok    = int'(elem_q[7:5]) < BUCKETS;
  assign word_ok    = int'(widx_q) < BUCKETS;
  assign range_sum  = {2'b00, elem_q} + {1'b0, len_q};
  assign range_last = range_sum - 10'd1;
  assign range_bad  = (len_q != 9'd0) && (int'(range_sum) > TOTAL);

  always_comb begin
    unique case (op_q) inside
      OP_ADD, OP_REMOVE, OP_CONTAINS:     bad = !elem_ok;
      OP_RANGE:                           bad = range_bad;
      OP_UNION, OP_INTERSECT:             bad = !word_ok;
      OP_NEXT, OP_ADD_ITER, OP_REM_ITER:  bad = iter_done;
      OP_CLEAR, OP_ANY, OP_FIRST:         bad = 1'b0;
      default:                            bad = 1'b1;
    endcase
  end

  // range mask for the bucket under the cursor
  assign range_first_b = AW'(elem_q[7:5]);
  assign range_last_b  = AW'(range_last[9:5]);
  assign last  = (cur == range_last_b);
  assign lo    = (cur == range_first_b) ? elem_q[4:0] : 5'd0;
  assign hi    = last ? range_last[4:0] : 5'd31;
  assign rmask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));

  assign mask_after = iter_mask & (iter_mask - 32'd1);
  assign scan_start = (op_q == OP_FIRST) ? '0 : SW'(iter_bucket) + SW'(1);

  // lowest nonzero bucket at or above the scan start
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (nz[i] && (SW'(i) >= scan_start)) begin
        hit     = 1'b1;
        hit_idx = AW'(i);
      end
    end
  end

  always_comb begin
    if (cmd.adv) begin
      raddr = cur + AW'(1);
    end else if (cmd.scan_rd) begin
      raddr = hit_idx;
    end else begin
      raddr = cur;
    end
  end

  assign bit_sel = (op_q == OP_ADD_ITER || op_q == OP_REM_ITER) ? iter_bit : elem_q[4:0];
  assign bit_oh  = 32'd1 << bit_sel;

  always_comb begin
    unique case (op_q) inside
      OP_ADD, OP_ADD_ITER:    wdata = word | bit_oh;
      OP_REMOVE, OP_REM_ITER: wdata = word & ~bit_oh;
      OP_UNION:               wdata = word | wbits_q;
      OP_INTERSECT:           wdata = word & wbits_q;
      OP_RANGE:               wdata = word | rmask;
      default:                wdata = word;
    endcase
  end

  assign wr_en = cmd.wr && (op_q != OP_CONTAINS);

  assign found_next = !bad &&
                      (((op_q == OP_CONTAINS) && word[elem_q[4:0]]) ||
                       ((op_q == OP_ANY) && (|nz)));

  // input beat and bucket cursor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      elem_q  <= element;
      len_q   <= range_length;
      widx_q  <= word_index;
      wbits_q <= word_bits;
      case (op) inside
        OP_ADD, OP_REMOVE, OP_CONTAINS, OP_RANGE: cur <= AW'(element[7:5]);
        OP_UNION, OP_INTERSECT:                   cur <= AW'(word_index);
        OP_ADD_ITER, OP_REM_ITER:                 cur <= iter_bucket;
        default:                                  cur <= cur;
      endcase
    end else if (cmd.adv) begin
      cur <= cur + AW'(1);
    end else if (cmd.scan_rd) begin
      cur <= hit_idx;
    end
  end

  // bucket memory
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q     <= mem[raddr];
      rd_valid <= valid_bits[raddr];
    end
    if (wr_en) begin
      mem[cur] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid_bits <= '0;
      nz         <= '0;
    end else if (wr_en) begin
      valid_bits[cur] <= 1'b1;
      nz[cur]         <= |wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_bucket <= '0;
      iter_mask   <= 32'd0;
      iter_bit    <= 5'd0;
      iter_done   <= 1'b1;
    end else if (cmd.step) begin
      iter_mask <= mask_after;
      iter_bit  <= lowest_set(mask_after);
    end else if (cmd.iter_end) begin
      iter_mask <= 32'd0;
      iter_done <= 1'b1;
    end else if (cmd.iter_load) begin
      iter_bucket <= cur;
      iter_mask   <= word;
      iter_bit    <= lowest_set(word);
      iter_done   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
      error_q <= 1'b0;
    end else if (cmd.fin) begin
      found_q <= found_next;
      error_q <= bad;
    end
  end

  assign sts.op       = op_q;
  assign sts.bad      = bad;
  assign sts.len_zero = (len_q == 9'd0);
  assign sts.more     = |mask_after;
  assign sts.hit      = hit;
  assign sts.last     = last;

  assign found    = found_q;
  assign error    = error_q;
  assign at_end   = iter_done;
  assign position = iter_done ? 8'd0 : 8'({iter_bucket, iter_bit});

endmodule

/* sv/bsi_controller.sv */
// controller of the bitset store: sequences decode, bucket reads and writes
// depends on bsi_pkg for op codes and the command and status bundles
module bsi_controller
  import bsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output bsi_cmd_t cmd,
  input  bsi_sts_t sts
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_MODIFY = 2'd2;
  localparam logic [1:0] S_LOAD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (sts.bad) begin
          cmd.fin = 1'b1;
        end else begin
          unique case (sts.op) inside
            OP_CLEAR: begin
              cmd.clr = 1'b1;
              cmd.fin = 1'b1;
            end
            OP_ANY: begin
              cmd.fin = 1'b1;
            end
            OP_FIRST, OP_NEXT: begin
              if (sts.op == OP_NEXT && sts.more) begin
                cmd.step = 1'b1;
                cmd.fin  = 1'b1;
              end else if (sts.hit) begin
                // fetch the lowest nonzero bucket at or above the scan start for the snapshot
                cmd.rd      = 1'b1;
                cmd.scan_rd = 1'b1;
                state_next  = S_LOAD;
              end else begin
                cmd.iter_end = 1'b1;
                cmd.fin      = 1'b1;
              end
            end
            OP_RANGE: begin
              if (sts.len_zero) begin
                cmd.fin = 1'b1;
              end else begin
                cmd.rd     = 1'b1;
                state_next = S_MODIFY;
              end
            end
            OP_ADD, OP_REMOVE, OP_CONTAINS, OP_UNION, OP_INTERSECT,
            OP_ADD_ITER, OP_REM_ITER: begin
              cmd.rd     = 1'b1;
              state_next = S_MODIFY;
            end
            default: begin
              cmd.fin = 1'b1;
            end
          endcase
        end
      end
      S_MODIFY: begin
        cmd.wr = 1'b1;
        // a range walks one bucket per cycle, reading ahead while writing
        if (sts.op == OP_RANGE && !sts.last) begin
          cmd.rd  = 1'b1;
          cmd.adv = 1'b1;
        end else begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.iter_load = 1'b1;
        cmd.fin       = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.fin;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* sv/bitset_store_with_iterator_top.sv */
// top level of the bitset store with a find-first-set iterator
// instantiates bsi_controller and bsi_datapath; depends on bsi_pkg
//
//  channel   handshake        payload
//  command   start, busy      op, element, range_length, word_index, word_bits
//  result    done (strobe)    found, position, at_end, error
//
// a beat is taken when start is high and busy is low; its result shows one
// cycle on done. clear, any, errors and a first or next that loads no bucket end in
// decode; single-bucket ops end in modify, and a first or next that loads a bucket in load;
// a range stays in modify for each bucket it touches (one write port on the memory).
// the scan over buckets uses per-bucket nonzero flags.
// rst is synchronous and empties the set at once; results cannot be stalled.
module bitset_store_with_iterator_top
  import bsi_pkg::*;
#(
  parameter int BUCKETS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic [7:0]  element,
  input  logic [8:0]  range_length,
  input  logic [2:0]  word_index,
  input  logic [31:0] word_bits,
  output logic        done,
  output logic        found,
  output logic [7:0]  position,
  output logic        at_end,
  output logic        error
);

  bsi_cmd_t cmd;
  bsi_sts_t sts;

  bsi_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  bsi_datapath #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .element      (element),
    .range_length (range_length),
    .word_index   (word_index),
    .word_bits    (word_bits),
    .found        (found),
    .position     (position),
    .at_end       (at_end),
    .error        (error)
  );

endmodule

/* sv/bsi_checker.sv */
// port-level checks of the bitset store, bound to the top level
// depends on bitset_store_with_iterator_top_defines.svh for the assertion macros
`include "bitset_store_with_iterator_top_defines.svh"

module bsi_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       found,
  input logic [7:0] position,
  input logic       at_end,
  input logic       error
);

  `BSI_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "no decode cycle after accept")
  `BSI_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `BSI_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `BSI_ASSERT_NOW(a_end_pos, done && at_end, position == 8'd0, "position nonzero at end")
  `BSI_ASSERT_NOW(a_err_found, done && error, !found, "found set on rejected beat")

endmodule

bind bitset_store_with_iterator_top bsi_checker u_bsi_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .found    (found),
  .position (position),
  .at_end   (at_end),
  .error    (error)
);

/* verif/tb_bitset_store_with_iterator_top.sv */
// testbench for bitset_store_with_iterator_top: directed and random command beats
// checked against an in-bench model of the set and its iterator; depends on bsi_pkg
`timescale 1ns / 100ps

module tb_bitset_store_with_iterator_top
  import bsi_pkg::*;
();

  localparam int NBUCKETS = 8;
  localparam int TOTAL_ELEMS = NBUCKETS * BUCKET_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_BEATS = 1525;
  localparam int MAX_SHOWN = 10;
  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  element;
    logic [8:0]  range_length;
    logic [2:0]  word_index;
    logic [31:0] word_bits;
  } set_cmd_t;

  typedef struct packed {
    logic       found;
    logic [7:0] position;
    logic       at_end;
    logic       error;
  } set_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  op;
  logic [7:0]  element;
  logic [8:0]  range_length;
  logic [2:0]  word_index;
  logic [31:0] word_bits;
  logic        done;
  logic        found;
  logic [7:0]  position;
  logic        at_end;
  logic        error;

  bitset_store_with_iterator_top #(.BUCKETS(NBUCKETS)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .element      (element),
    .range_length (range_length),
    .word_index   (word_index),
    .word_bits    (word_bits),
    .done         (done),
    .found        (found),
    .position     (position),
    .at_end       (at_end),
    .error        (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the set and the iterator
  logic [31:0] set_words [NBUCKETS];
  int unsigned walk_bucket;
  logic [31:0] walk_snapshot;
  logic [4:0]  walk_bit;
  logic        walk_done;

  set_reply_t pending_replies [$];
  bit   gaps_on;
  int   beats_sent;
  int   directed_beats;
  int   replies_checked;
  int   rejected_beats;
  int   end_hits;
  int   mismatch_count;

  function automatic logic [4:0] lowest_set(input logic [31:0] w);
    int i;
    lowest_set = 5'd0;
    for (i = 31; i >= 0; i--)
      if (w[i]) lowest_set = 5'(i);
  endfunction

  // position the iterator on the first live bucket at or after from
  function automatic void seek_bucket(input int unsigned from);
    int unsigned b;
    for (b = from; b < NBUCKETS; b++) begin
      if (set_words[b] != 32'd0) begin
        walk_bucket   = b;
        walk_snapshot = set_words[b];
        walk_bit      = lowest_set(set_words[b]);
        walk_done     = 1'b0;
        return;
      end
    end
    walk_snapshot = 32'd0;
    walk_done     = 1'b1;
  endfunction

  function automatic set_reply_t predict_reply(input set_cmd_t c);
    set_reply_t  r;
    int unsigned bk;
    int unsigned bt;
    int unsigned e;
    int unsigned last;
    int unsigned b;
    r  = '0;
    bk = c.element / BUCKET_BITS;
    bt = c.element % BUCKET_BITS;
    last = int'(c.element) + int'(c.range_length);
    case (c.op)
      OP_CLEAR: begin
        for (b = 0; b < NBUCKETS; b++) set_words[b] = 32'd0;
      end
      OP_ADD, OP_REMOVE, OP_CONTAINS: begin
        if (bk >= NBUCKETS) r.error = 1'b1;
        else if (c.op == OP_ADD) set_words[bk][bt] = 1'b1;
        else if (c.op == OP_REMOVE) set_words[bk][bt] = 1'b0;
        else r.found = set_words[bk][bt];
      end
      OP_RANGE: begin
        if (c.range_length != 9'd0) begin
          if (last > TOTAL_ELEMS) r.error = 1'b1;
          else
            for (e = c.element; e < last; e++)
              set_words[e / BUCKET_BITS][e % BUCKET_BITS] = 1'b1;
        end
      end
      OP_UNION, OP_INTERSECT: begin
        if (c.word_index >= NBUCKETS) r.error = 1'b1;
        else if (c.op == OP_UNION) set_words[c.word_index] |= c.word_bits;
        else set_words[c.word_index] &= c.word_bits;
      end
      OP_ANY: begin
        for (b = 0; b < NBUCKETS; b++)
          if (set_words[b] != 32'd0) r.found = 1'b1;
      end
      OP_FIRST: seek_bucket(0);
      OP_NEXT: begin
        if (walk_done) r.error = 1'b1;
        else begin
          walk_snapshot &= walk_snapshot - 32'd1;
          if (walk_snapshot != 32'd0) walk_bit = lowest_set(walk_snapshot);
          else seek_bucket(walk_bucket + 1);
        end
      end
      OP_ADD_ITER, OP_REM_ITER: begin
        if (walk_done || walk_bucket >= NBUCKETS) r.error = 1'b1;
        else set_words[walk_bucket][walk_bit] = (c.op == OP_ADD_ITER);
      end
      default: r.error = 1'b1;
    endcase
    r.at_end   = walk_done;
    r.position = walk_done ? 8'd0 : 8'(walk_bucket * BUCKET_BITS + walk_bit);
    return r;
  endfunction

  function automatic set_cmd_t mk(input logic [3:0] o, input int el, input int len,
                                  input int wi, input logic [31:0] wb);
    set_cmd_t c;
    c.op           = o;
    c.element      = 8'(el);
    c.range_length = 9'(len);
    c.word_index   = 3'(wi);
    c.word_bits    = wb;
    return c;
  endfunction

  // drive one command beat and wait until the block takes it
  task automatic send_cmd(input set_cmd_t c);
    set_reply_t r;
    @(negedge clk);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 36) begin
        start        <= 1'b0;
        op           <= 4'($urandom);
        element      <= 8'($urandom);
        range_length <= 9'($urandom);
        word_index   <= 3'($urandom);
        word_bits    <= $urandom;
        @(negedge clk);
      end
    end
    start        <= 1'b1;
    op           <= c.op;
    element      <= c.element;
    range_length <= c.range_length;
    word_index   <= c.word_index;
    word_bits    <= c.word_bits;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_reply(c);
    if (r.error) rejected_beats++;
    if (c.op == OP_NEXT && !r.error && r.at_end) end_hits++;
    pending_replies.push_back(r);
    beats_sent++;
  endtask

  // result checker: every strobe must match the oldest prediction
  always @(posedge clk) begin
    set_reply_t want;
    set_reply_t got;
    if (!rst && done === 1'b1) begin
      got = '{found, position, at_end, error};
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected reply: found=%b position=%0d at_end=%b error=%b",
                   found, position, at_end, error);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("reply %0d mismatch: exp found=%b pos=%0d end=%b err=%b,",
                     replies_checked, want.found, want.position, want.at_end,
                     want.error, " got found=%b pos=%0d end=%b err=%b",
                     found, position, at_end, error);
        end
      end
    end
  end

  // watchdog on cycles without a taken beat or a reply
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_idle_state;
    send_cmd(mk(OP_ANY, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_REM_ITER, 0, 0, 0, 32'd0));
  endtask

  task automatic test_elements;
    send_cmd(mk(OP_ADD, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_ADD, 255, 0, 0, 32'd0));
    send_cmd(mk(OP_CONTAINS, 255, 0, 0, 32'd0));
    send_cmd(mk(OP_REMOVE, 255, 0, 0, 32'd0));
  endtask

  task automatic test_ranges;
    // empty range at the top start is a no-op, one past the end is rejected
    send_cmd(mk(OP_RANGE, 255, 0, 0, 32'd0));
    send_cmd(mk(OP_RANGE, 251, 6, 0, 32'd0));
    send_cmd(mk(OP_RANGE, 0, 256, 0, 32'd0));
    send_cmd(mk(OP_RANGE, 1, 511, 7, 32'hFFFF_FFFF));
    send_cmd(mk(OP_CLEAR, 0, 0, 0, 32'd0));
  endtask

  task automatic test_words;
    send_cmd(mk(OP_UNION, 0, 0, 7, 32'hFFFF_FFFF));
    send_cmd(mk(OP_INTERSECT, 0, 0, 7, 32'h8000_0001));
  endtask

  task automatic test_iterator;
    send_cmd(mk(OP_UNION, 0, 0, 0, 32'h0001_8000));
    send_cmd(mk(OP_FIRST, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_REM_ITER, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_ADD_ITER, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
    // clear keeps the snapshot, so the walk goes on inside bucket 7
    send_cmd(mk(OP_CLEAR, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
  endtask

  task automatic test_unused_ops;
    send_cmd(mk(OP_UNUSED_LO, 0, 0, 0, 32'd0));
    send_cmd(mk(OP_UNUSED_HI, 255, 511, 7, 32'hFFFF_FFFF));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom & $urandom & $urandom;
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic set_cmd_t rand_cmd();
    set_cmd_t c;
    int pick;
    int lsel;
    pick = $urandom_range(0, 99);
    lsel = $urandom_range(0, 99);
    c.element      = 8'($urandom_range(0, 255));
    c.word_index   = 3'($urandom_range(0, 7));
    c.word_bits    = rand_word();
    c.range_length = lsel < 80 ? 9'($urandom_range(0, 40)) :
                     lsel < 95 ? 9'($urandom_range(0, 256)) : 9'($urandom_range(257, 511));
    if (pick < 2) c.op = OP_CLEAR;
    else if (pick < 14) c.op = OP_ADD;
    else if (pick < 22) c.op = OP_REMOVE;
    else if (pick < 30) c.op = OP_CONTAINS;
    else if (pick < 38) c.op = OP_RANGE;
    else if (pick < 46) c.op = OP_UNION;
    else if (pick < 52) c.op = OP_INTERSECT;
    else if (pick < 56) c.op = OP_ANY;
    else if (pick < 62) c.op = OP_FIRST;
    else if (pick < 84) c.op = OP_NEXT;
    else if (pick < 90) c.op = OP_ADD_ITER;
    else if (pick < 96) c.op = OP_REM_ITER;
    else c.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return c;
  endfunction

  // half of the rounds are iterator walks with edits in between, the rest random bursts
  task automatic test_random_mix;
    set_cmd_t c;
    int counted;
    int steps;
    int n;
    int i;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      // one stretch runs with the sender never pausing
      gaps_on = !(counted > 500 && counted < 800);
      if ($urandom_range(0, 1) == 0) begin
        send_cmd(mk(OP_FIRST, 0, 0, 0, 32'd0));
        counted++;
        steps = 0;
        while (!walk_done && steps < 40) begin
          if ($urandom_range(0, 99) < 70) c = mk(OP_NEXT, 0, 0, 0, 32'd0);
          else c = rand_cmd();
          send_cmd(c);
          if (c.op < OP_UNUSED_LO) counted++;
          steps++;
        end
        send_cmd(mk(OP_NEXT, 0, 0, 0, 32'd0));
        counted++;
      end else begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
          c = rand_cmd();
          send_cmd(c);
          if (c.op < OP_UNUSED_LO) counted++;
        end
      end
    end
  endtask

  initial begin
    int b;
    int leftover;
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_CLEAR;
    element      = 8'd0;
    range_length = 9'd0;
    word_index   = 3'd0;
    word_bits    = 32'd0;
    gaps_on      = 1'b1;
    beats_sent = 0;
    replies_checked = 0;
    rejected_beats = 0;
    end_hits = 0;
    mismatch_count = 0;
    for (b = 0; b < NBUCKETS; b++) set_words[b] = 32'd0;
    walk_bucket   = 0;
    walk_snapshot = 32'd0;
    walk_bit      = 5'd0;
    walk_done     = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_state();
    test_elements();
    test_ranges();
    test_words();
    test_iterator();
    test_unused_ops();
    directed_beats = beats_sent;
    test_random_mix();

    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    leftover = pending_replies.size();
    $display("covered %0d command beats (%0d directed), %0d replies checked",
             beats_sent, directed_beats, replies_checked);
    $display("%0d beats rejected, %0d walks ran off the end, %0d mismatches",
             rejected_beats, end_hits, mismatch_count);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
